[rtl/assert_macros.svh]
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

[rtl/ctkd_pkg.sv]
// shared constants and types for the capacitive touch key detector
package ctkd_pkg;

  localparam int SAMPLE_BITS_DEF   = 16;
  localparam int MARGIN_BITS       = 16;
  localparam int CFG_DATA_BITS     = 16;
  localparam int CFG_IDX_BITS      = 1;

  localparam int CALIB_GROUP       = 10;
  localparam int SCAN_GROUP_SINGLE = 3;
  localparam int SCAN_GROUP_CONT   = 6;
  localparam int LOCKOUT_RELOAD    = 3;

  localparam logic [MARGIN_BITS-1:0] MARGIN_RESET = 16'd100;

  localparam logic OP_CALIB   = 1'b0;
  localparam logic OP_SCAN    = 1'b1;
  localparam logic KIND_CALIB = 1'b0;
  localparam logic KIND_SCAN  = 1'b1;

  localparam logic [CFG_IDX_BITS-1:0] CFG_IDX_CONT   = 1'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_IDX_MARGIN = 1'd1;

  // calibration unit status toward the top level
  typedef struct packed {
    logic pend;  // middle sum captured, baseline divide waiting
    logic done;  // baseline written this cycle
  } calib_stat_t;

endpackage

[rtl/ctkd_calib.sv]
// calibration accumulator: sum, two smallest, two largest, divide by six
module ctkd_calib #(
  parameter int SAMPLE_BITS = ctkd_pkg::SAMPLE_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    sample_fire,
  input  logic [SAMPLE_BITS-1:0]  sample,
  input  logic                    div_go,
  output ctkd_pkg::calib_stat_t   stat,
  output logic [SAMPLE_BITS-1:0]  baseline,
  output logic [SAMPLE_BITS-1:0]  baseline_new
);
  import ctkd_pkg::*;

  localparam int SUM_BITS   = SAMPLE_BITS + 4;
  localparam int MID_BITS   = SAMPLE_BITS + 3;
  localparam int HALF_BITS  = SAMPLE_BITS + 2;
  localparam int PROD_BITS  = 2 * HALF_BITS;
  localparam int DIV3_SHIFT = HALF_BITS + 1;
  localparam logic [HALF_BITS-1:0] DIV3_MUL =
    HALF_BITS'(((64'd1 << (HALF_BITS + 1)) + 64'd2) / 64'd3);
  localparam logic [3:0] CALIB_LAST = 4'(CALIB_GROUP - 1);

  logic [SUM_BITS-1:0]    sum_r, sum_nxt, sum_upd;
  logic [SAMPLE_BITS-1:0] sml0_r, sml0_nxt, sml0_upd;
  logic [SAMPLE_BITS-1:0] sml1_r, sml1_nxt, sml1_upd;
  logic [SAMPLE_BITS-1:0] lrg0_r, lrg0_nxt, lrg0_upd;
  logic [SAMPLE_BITS-1:0] lrg1_r, lrg1_nxt, lrg1_upd;
  logic [3:0]             cnt_r, cnt_nxt;
  logic [MID_BITS-1:0]    mid_r, mid_nxt;
  logic [SUM_BITS-1:0]    mid_full;
  logic                   pend_r, pend_nxt;
  logic [SAMPLE_BITS-1:0] base_r, base_nxt;
  logic [HALF_BITS-1:0]   half;
  logic [PROD_BITS-1:0]   prod;

  always_comb begin
    sum_upd  = sum_r + SUM_BITS'(sample);
    sml0_upd = sml0_r;
    sml1_upd = sml1_r;
    lrg0_upd = lrg0_r;
    lrg1_upd = lrg1_r;
    if (sample < sml0_r) begin
      sml1_upd = sml0_r;
      sml0_upd = sample;
    end else if (sample < sml1_r) begin
      sml1_upd = sample;
    end
    if (sample > lrg0_r) begin
      lrg1_upd = lrg0_r;
      lrg0_upd = sample;
    end else if (sample > lrg1_r) begin
      lrg1_upd = sample;
    end
    mid_full = sum_upd - SUM_BITS'(sml0_upd) - SUM_BITS'(sml1_upd)
             - SUM_BITS'(lrg0_upd) - SUM_BITS'(lrg1_upd);
  end

  // x / 6 as (x / 2) / 3, the divide by 3 through a reciprocal multiply
  always_comb begin
    half         = mid_r[MID_BITS-1:1];
    prod         = PROD_BITS'(half) * PROD_BITS'(DIV3_MUL);
    baseline_new = prod[DIV3_SHIFT +: SAMPLE_BITS];
  end

  always_comb begin
    sum_nxt  = sum_r;
    sml0_nxt = sml0_r;
    sml1_nxt = sml1_r;
    lrg0_nxt = lrg0_r;
    lrg1_nxt = lrg1_r;
    cnt_nxt  = cnt_r;
    mid_nxt  = mid_r;
    pend_nxt = pend_r;
    base_nxt = base_r;
    if (div_go) begin
      pend_nxt = 1'b0;
      base_nxt = baseline_new;
    end
    if (sample_fire) begin
      if (cnt_r == CALIB_LAST) begin
        mid_nxt  = mid_full[MID_BITS-1:0];
        pend_nxt = 1'b1;
        sum_nxt  = '0;
        sml0_nxt = '1;
        sml1_nxt = '1;
        lrg0_nxt = '0;
        lrg1_nxt = '0;
        cnt_nxt  = '0;
      end else begin
        sum_nxt  = sum_upd;
        sml0_nxt = sml0_upd;
        sml1_nxt = sml1_upd;
        lrg0_nxt = lrg0_upd;
        lrg1_nxt = lrg1_upd;
        cnt_nxt  = cnt_r + 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r  <= '0;
      sml0_r <= '1;
      sml1_r <= '1;
      lrg0_r <= '0;
      lrg1_r <= '0;
      cnt_r  <= '0;
      pend_r <= 1'b0;
      base_r <= '0;
    end else begin
      sum_r  <= sum_nxt;
      sml0_r <= sml0_nxt;
      sml1_r <= sml1_nxt;
      lrg0_r <= lrg0_nxt;
      lrg1_r <= lrg1_nxt;
      cnt_r  <= cnt_nxt;
      pend_r <= pend_nxt;
      base_r <= base_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mid_r <= mid_nxt;
  end

  assign stat.pend = pend_r;
  assign stat.done = div_go;
  assign baseline  = base_r;

endmodule

[rtl/ctkd_scan.sv]
// scan group peak tracking, touch window check and lockout counter
module ctkd_scan #(
  parameter int SAMPLE_BITS = ctkd_pkg::SAMPLE_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               sample_fire,
  input  logic [SAMPLE_BITS-1:0]             sample,
  input  logic [SAMPLE_BITS-1:0]             baseline,
  input  logic                               cont_mode,
  input  logic [ctkd_pkg::MARGIN_BITS-1:0]   margin,
  output logic                               done,
  output logic                               press,
  output logic [SAMPLE_BITS-1:0]             peak
);
  import ctkd_pkg::*;

  localparam int CMP_BITS = ((SAMPLE_BITS > MARGIN_BITS) ? SAMPLE_BITS : MARGIN_BITS) + 1;
  localparam int TEN_BITS = SAMPLE_BITS + 4;

  logic [SAMPLE_BITS-1:0] peak_r, peak_nxt;
  logic [2:0]             cnt_r, cnt_nxt, cnt_upd, group;
  logic [1:0]             lock_r, lock_nxt, lock_in, lock_set;
  logic [CMP_BITS-1:0]    floor_lvl;
  logic [TEN_BITS-1:0]    ceil_lvl;
  logic                   touch_ok;

  always_comb begin
    group     = cont_mode ? 3'(SCAN_GROUP_CONT) : 3'(SCAN_GROUP_SINGLE);
    peak      = (sample > peak_r) ? sample : peak_r;
    cnt_upd   = cnt_r + 3'd1;
    done      = sample_fire && (cnt_upd >= group);
    floor_lvl = CMP_BITS'(baseline) + CMP_BITS'(margin);
    // ten times baseline as 8b + 2b
    ceil_lvl  = (TEN_BITS'(baseline) << 3) + (TEN_BITS'(baseline) << 1);
    touch_ok  = (CMP_BITS'(peak) > floor_lvl) && (TEN_BITS'(peak) < ceil_lvl);
    lock_in   = cont_mode ? 2'd0 : lock_r;
    press     = touch_ok && (lock_in == 2'd0);
    lock_set  = touch_ok ? 2'(LOCKOUT_RELOAD) : lock_in;

    peak_nxt = peak_r;
    cnt_nxt  = cnt_r;
    lock_nxt = lock_r;
    if (done) begin
      peak_nxt = '0;
      cnt_nxt  = '0;
      lock_nxt = (lock_set != 2'd0) ? lock_set - 2'd1 : 2'd0;
    end else if (sample_fire) begin
      peak_nxt = peak;
      cnt_nxt  = cnt_upd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      peak_r <= '0;
      cnt_r  <= '0;
      lock_r <= '0;
    end else begin
      peak_r <= peak_nxt;
      cnt_r  <= cnt_nxt;
      lock_r <= lock_nxt;
    end
  end

endmodule

[rtl/capacitive_touch_key_detector_unit.sv]
// path: a scan decision passes the input and result registers; a calibration result
// passes the input, middle-sum and result registers
// throughput: one sample per cycle while the result register can load; after the tenth
// calibration sample the input holds until the divide-by-six baseline is registered
// reset: synchronous active-low rst_n clears accumulators, lockout, baseline, cont mode
module capacitive_touch_key_detector_unit #(
  parameter int SAMPLE_BITS = ctkd_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 in_op,
  input  logic [SAMPLE_BITS-1:0]               in_charge_time,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic                                 out_result_kind,
  output logic [SAMPLE_BITS-1:0]               out_baseline_value,
  output logic [SAMPLE_BITS-1:0]               out_peak_value,
  output logic                                 out_pressed,
  input  logic                                 cfg_we,
  input  logic [ctkd_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  logic [ctkd_pkg::CFG_DATA_BITS-1:0]   cfg_wdata
);
  import ctkd_pkg::*;

  logic                   cont_r, cont_nxt;
  logic [MARGIN_BITS-1:0] margin_r, margin_nxt;

  logic                   s1_v_r, s1_v_nxt;
  logic                   s1_op_r;
  logic [SAMPLE_BITS-1:0] s1_x_r;

  logic                   out_v_r, out_v_nxt;
  logic                   out_kind_r, out_kind_nxt;
  logic [SAMPLE_BITS-1:0] out_base_r, out_base_nxt;
  logic [SAMPLE_BITS-1:0] out_peak_r, out_peak_nxt;
  logic                   out_press_r, out_press_nxt;

  logic                   out_can_load, s1_fire, in_fire;
  logic                   calib_fire, scan_fire, div_go;
  calib_stat_t            cstat;
  logic [SAMPLE_BITS-1:0] baseline, baseline_new;
  logic                   scan_done, scan_press;
  logic [SAMPLE_BITS-1:0] scan_peak;

  assign out_can_load = !out_v_r || out_ready;
  assign s1_fire      = s1_v_r && out_can_load && !cstat.pend;
  assign in_ready     = !s1_v_r || s1_fire;
  assign in_fire      = in_valid && in_ready;
  assign calib_fire   = s1_fire && (s1_op_r == OP_CALIB);
  assign scan_fire    = s1_fire && (s1_op_r == OP_SCAN);
  assign div_go       = cstat.pend && out_can_load;

  ctkd_calib #(.SAMPLE_BITS(SAMPLE_BITS)) u_calib (
    .clk          (clk),
    .rst_n        (rst_n),
    .sample_fire  (calib_fire),
    .sample       (s1_x_r),
    .div_go       (div_go),
    .stat         (cstat),
    .baseline     (baseline),
    .baseline_new (baseline_new)
  );

  ctkd_scan #(.SAMPLE_BITS(SAMPLE_BITS)) u_scan (
    .clk         (clk),
    .rst_n       (rst_n),
    .sample_fire (scan_fire),
    .sample      (s1_x_r),
    .baseline    (baseline),
    .cont_mode   (cont_r),
    .margin      (margin_r),
    .done        (scan_done),
    .press       (scan_press),
    .peak        (scan_peak)
  );

  always_comb begin
    cont_nxt   = cont_r;
    margin_nxt = margin_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_IDX_CONT:   cont_nxt   = cfg_wdata[0];
        CFG_IDX_MARGIN: margin_nxt = cfg_wdata[MARGIN_BITS-1:0];
        default:        ;
      endcase
    end
  end

  always_comb begin
    s1_v_nxt = s1_v_r;
    if (in_fire) begin
      s1_v_nxt = 1'b1;
    end else if (s1_fire) begin
      s1_v_nxt = 1'b0;
    end
  end

  // result register: calibration divide result or scan decision
  always_comb begin
    out_v_nxt     = out_v_r && !out_ready;
    out_kind_nxt  = out_kind_r;
    out_base_nxt  = out_base_r;
    out_peak_nxt  = out_peak_r;
    out_press_nxt = out_press_r;
    if (cstat.done) begin
      out_v_nxt     = 1'b1;
      out_kind_nxt  = KIND_CALIB;
      out_base_nxt  = baseline_new;
      out_peak_nxt  = '0;
      out_press_nxt = 1'b0;
    end else if (scan_done) begin
      out_v_nxt     = 1'b1;
      out_kind_nxt  = KIND_SCAN;
      out_base_nxt  = baseline;
      out_peak_nxt  = scan_peak;
      out_press_nxt = scan_press;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cont_r   <= 1'b0;
      margin_r <= MARGIN_RESET;
      s1_v_r   <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      cont_r   <= cont_nxt;
      margin_r <= margin_nxt;
      s1_v_r   <= s1_v_nxt;
      out_v_r  <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_op_r <= in_op;
      s1_x_r  <= in_charge_time;
    end
    out_kind_r  <= out_kind_nxt;
    out_base_r  <= out_base_nxt;
    out_peak_r  <= out_peak_nxt;
    out_press_r <= out_press_nxt;
  end

  assign out_valid          = out_v_r;
  assign out_result_kind    = out_kind_r;
  assign out_baseline_value = out_base_r;
  assign out_peak_value     = out_peak_r;
  assign out_pressed        = out_press_r;

endmodule

[rtl/ctkd_checker.sv]
// port-level checks for the touch key detector, bound to the top level
`include "assert_macros.svh"

module ctkd_checker #(
  parameter int SAMPLE_BITS = ctkd_pkg::SAMPLE_BITS_DEF
) (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   out_valid,
  input logic                   out_ready,
  input logic                   out_result_kind,
  input logic [SAMPLE_BITS-1:0] out_baseline_value,
  input logic [SAMPLE_BITS-1:0] out_peak_value,
  input logic                   out_pressed
);
  import ctkd_pkg::*;

  // a stalled result transaction holds
  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_peak_value) && $stable(out_baseline_value) && $stable(out_pressed))

  // calibration results carry no peak and no press
  `ASSERT_SAME(a_calib_clean, clk, rst_n, out_valid && (out_result_kind == KIND_CALIB), (out_peak_value == '0) && !out_pressed)

  // a press only comes with a scan decision
  `ASSERT_SAME(a_press_scan, clk, rst_n, out_valid && out_pressed, out_result_kind == KIND_SCAN)

  // a press needs the peak above the baseline
  `ASSERT_SAME(a_press_above, clk, rst_n, out_valid && out_pressed, out_peak_value > out_baseline_value)

endmodule

bind capacitive_touch_key_detector_unit ctkd_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_ctkd_checker (.*);
